@@ rtl/gasc_pkg.sv @@
// ----------------------------------------------------------------------------
// gasc_pkg
// Shared types and defaults for the glyph atlas shelf cache.
// ----------------------------------------------------------------------------
package gasc_pkg;

  localparam int ATLAS_WIDTH_DEF  = 128;
  localparam int ATLAS_HEIGHT_DEF = 128;
  localparam int SLOT_COUNT_DEF   = 256;

  localparam int CSLOT_W = 9;
  localparam int GLYPH_W = 8;
  localparam int OUT_W   = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HIT,
    ST_ROW,
    ST_TOP,
    ST_TOP_RD,
    ST_TOP_CHK,
    ST_BAND,
    ST_BAND_RD,
    ST_BAND_CHK,
    ST_PLACE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_cslot;
    logic flush_emit;
    logic hit_emit;
    logic row_wrap;
    logic top_wrap;
    logic band_setup;
    logic set_rh;
    logic evict;
    logic place;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic hit_ok;
    logic row_ovf;
    logic top_ovf;
    logic ring_empty;
    logic top_stop;
    logic taller;
    logic band_stop;
    logic full;
  } stat_t;

endpackage

@@ rtl/gasc_ctrl.sv @@
// ----------------------------------------------------------------------------
// gasc_ctrl
// Sequencer for lookup, flush, shelf wrap and eviction walks.
// ----------------------------------------------------------------------------
module gasc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  input  gasc_pkg::stat_t stat,
  output gasc_pkg::cmd_t  cmd
);
  import gasc_pkg::*;

  state_t state_r, state_nxt;
  logic   strobe_r, strobe_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.rd_cslot = 1'b1;
        if (start) begin
          cmd.load = 1'b1;
          if (stat.mode) begin
            cmd.flush_emit = 1'b1;
          end else if (stat.hit_ok) begin
            state_nxt = ST_HIT;
          end else begin
            state_nxt = ST_ROW;
          end
        end
      end
      ST_HIT: begin
        cmd.hit_emit = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_ROW: begin
        cmd.row_wrap = stat.row_ovf;
        state_nxt    = ST_TOP;
      end
      ST_TOP: begin
        if (stat.top_ovf) begin
          cmd.top_wrap = 1'b1;
          state_nxt    = ST_TOP_RD;
        end else begin
          state_nxt = ST_BAND;
        end
      end
      ST_TOP_RD: begin
        state_nxt = stat.ring_empty ? ST_BAND : ST_TOP_CHK;
      end
      ST_TOP_CHK: begin
        if (stat.top_stop) begin
          state_nxt = ST_BAND;
        end else begin
          cmd.evict = 1'b1;
          state_nxt = ST_TOP_RD;
        end
      end
      ST_BAND: begin
        cmd.band_setup = 1'b1;
        state_nxt      = stat.taller ? ST_BAND_RD : ST_PLACE;
      end
      ST_BAND_RD: begin
        if (stat.ring_empty) begin
          cmd.set_rh = 1'b1;
          state_nxt  = ST_PLACE;
        end else begin
          state_nxt = ST_BAND_CHK;
        end
      end
      ST_BAND_CHK: begin
        if (stat.band_stop) begin
          cmd.set_rh = 1'b1;
          state_nxt  = ST_PLACE;
        end else begin
          cmd.evict = 1'b1;
          state_nxt = ST_BAND_RD;
        end
      end
      ST_PLACE: begin
        cmd.evict = stat.full;
        cmd.place = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    strobe_nxt = cmd.flush_emit | cmd.hit_emit | cmd.place;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = strobe_r;

endmodule

@@ rtl/gasc_dp.sv @@
// ----------------------------------------------------------------------------
// gasc_dp
// Ring pointers, shelf cursor, origin memory and result registers.
// ----------------------------------------------------------------------------
module gasc_dp #(
  parameter int ATLAS_WIDTH  = gasc_pkg::ATLAS_WIDTH_DEF,
  parameter int ATLAS_HEIGHT = gasc_pkg::ATLAS_HEIGHT_DEF,
  parameter int SLOT_COUNT   = gasc_pkg::SLOT_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_mode,
  input  logic [gasc_pkg::CSLOT_W-1:0] in_cached_slot,
  input  logic [gasc_pkg::GLYPH_W-1:0] in_glyph_width,
  input  logic [gasc_pkg::GLYPH_W-1:0] in_glyph_height,
  input  gasc_pkg::cmd_t               cmd,
  output gasc_pkg::stat_t              stat,
  output logic [gasc_pkg::OUT_W-1:0]   out_slot,
  output logic [gasc_pkg::OUT_W-1:0]   out_origin_x,
  output logic [gasc_pkg::OUT_W-1:0]   out_origin_y,
  output logic                         out_hit,
  output logic [gasc_pkg::OUT_W-1:0]   out_evict_from,
  output logic [gasc_pkg::OUT_W-1:0]   out_evict_to,
  output logic                         out_flushed
);
  import gasc_pkg::*;

  localparam int PW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int XW  = $clog2(ATLAS_WIDTH + 1);
  localparam int YW  = $clog2(ATLAS_HEIGHT + 1);
  localparam int CW  = (PW + 1 > CSLOT_W) ? PW + 1 : CSLOT_W;
  localparam int WCW = (XW > GLYPH_W) ? XW : GLYPH_W;
  localparam int HCW = (YW > GLYPH_W) ? YW : GLYPH_W;
  localparam int MW  = XW + YW;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PW'(SLOT_COUNT - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_dist(input logic [PW-1:0] a,
                                              input logic [PW-1:0] b);
    logic [PW:0] t;
    t = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      t = t + (PW+1)'(SLOT_COUNT);
    end
    return PW'(t);
  endfunction

  logic [MW-1:0] mem [SLOT_COUNT];
  logic [MW-1:0] rd_data_r;
  logic [PW-1:0] rd_addr;

  logic [PW-1:0] oldest_r, next_r, base_r;
  logic [XW-1:0] cx_r, w_r;
  logic [YW-1:0] cy_r, rh_r, h_r, y0_r, y1_r;
  logic [PW-1:0] s_r, from_r;

  logic [CW-1:0]  cs_ext;
  logic [PW-1:0]  cs_idx;
  logic           cs_in_range;
  logic [WCW-1:0] w_ext;
  logic [HCW-1:0] h_ext;
  logic [XW-1:0]  w_sat;
  logic [YW-1:0]  h_sat;
  logic [PW-1:0]  oldest_inc;
  logic [XW-1:0]  rd_x;
  logic [YW-1:0]  rd_y;

  assign cs_ext      = CW'(in_cached_slot);
  assign cs_idx      = PW'(cs_ext);
  assign cs_in_range = (cs_ext < CW'(SLOT_COUNT));
  assign w_ext       = WCW'(in_glyph_width);
  assign h_ext       = HCW'(in_glyph_height);
  assign w_sat       = (w_ext > WCW'(ATLAS_WIDTH))  ? XW'(ATLAS_WIDTH)  : XW'(w_ext);
  assign h_sat       = (h_ext > HCW'(ATLAS_HEIGHT)) ? YW'(ATLAS_HEIGHT) : YW'(h_ext);
  assign oldest_inc  = ring_next(oldest_r);
  assign rd_x        = rd_data_r[MW-1:YW];
  assign rd_y        = rd_data_r[YW-1:0];
  assign rd_addr     = cmd.rd_cslot ? cs_idx : oldest_r;

  always_comb begin
    stat.mode       = in_mode;
    stat.hit_ok     = cs_in_range &&
                      (ring_dist(cs_idx, base_r) < ring_dist(next_r, base_r));
    stat.row_ovf    = ({1'b0, cx_r} + {1'b0, w_r}) > (XW+1)'(ATLAS_WIDTH);
    stat.top_ovf    = ({1'b0, cy_r} + {1'b0, h_r}) > (YW+1)'(ATLAS_HEIGHT);
    stat.ring_empty = (oldest_r == next_r);
    stat.top_stop   = (rd_y == '0);
    stat.taller     = (h_r > rh_r);
    stat.band_stop  = (rd_y < y0_r) || (rd_y >= y1_r);
    stat.full       = (ring_next(next_r) == oldest_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      mem[next_r] <= {cx_r, cy_r};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      next_r   <= '0;
      base_r   <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      rh_r     <= '0;
    end else begin
      if (cmd.flush_emit) begin
        base_r <= next_r;
      end
      if (cmd.evict) begin
        oldest_r <= oldest_inc;
        if (base_r == oldest_r) begin
          base_r <= oldest_inc;
        end
      end
      if (cmd.row_wrap) begin
        cy_r <= cy_r + rh_r;
        cx_r <= '0;
        rh_r <= '0;
      end
      if (cmd.top_wrap) begin
        cy_r <= '0;
        cx_r <= '0;
        rh_r <= '0;
      end
      if (cmd.set_rh) begin
        rh_r <= h_r;
      end
      if (cmd.place) begin
        cx_r   <= cx_r + w_r;
        next_r <= ring_next(next_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r    <= w_sat;
      h_r    <= h_sat;
      s_r    <= cs_idx;
      from_r <= oldest_r;
    end
    if (cmd.band_setup) begin
      y0_r <= cy_r + rh_r;
      y1_r <= cy_r + h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_emit) begin
      out_slot       <= '0;
      out_origin_x   <= '0;
      out_origin_y   <= '0;
      out_hit        <= 1'b0;
      out_evict_from <= OUT_W'(oldest_r);
      out_evict_to   <= OUT_W'(oldest_r);
      out_flushed    <= 1'b1;
    end else if (cmd.hit_emit) begin
      out_slot       <= OUT_W'(s_r);
      out_origin_x   <= OUT_W'(rd_x);
      out_origin_y   <= OUT_W'(rd_y);
      out_hit        <= 1'b1;
      out_evict_from <= OUT_W'(oldest_r);
      out_evict_to   <= OUT_W'(oldest_r);
      out_flushed    <= 1'b0;
    end else if (cmd.place) begin
      out_slot       <= OUT_W'(next_r);
      out_origin_x   <= OUT_W'(cx_r);
      out_origin_y   <= OUT_W'(cy_r);
      out_hit        <= 1'b0;
      out_evict_from <= OUT_W'(from_r);
      out_evict_to   <= OUT_W'(cmd.evict ? oldest_inc : oldest_r);
      out_flushed    <= 1'b0;
    end
  end

endmodule

@@ rtl/glyph_atlas_shelf_cache_core.sv @@
// ----------------------------------------------------------------------------
// glyph_atlas_shelf_cache_core
// Shelf-packing glyph atlas allocator with a FIFO-evicted slot ring.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start / busy       in_mode, in_cached_slot, in_glyph_width/height
//  result    out_valid strobe   out_slot, out_origin_x/y, out_hit,
//                               out_evict_from/to, out_flushed
//
//  Flush: result strobe on the following cycle, busy stays low.
//  Hit: a registered read of the origin memory, then the result strobe.
//  Miss: row wrap check, top wrap check and, if needed, an eviction walk from
//  the top, band setup and, if needed, an eviction walk over the band, then
//  placement; each walk step is a read of the origin memory followed by a compare.
//  Reset is synchronous; no clearing pass is needed, valid slots are derived
//  from the ring pointers and a flush boundary pointer.
//  The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module glyph_atlas_shelf_cache_core #(
  parameter int ATLAS_WIDTH  = gasc_pkg::ATLAS_WIDTH_DEF,
  parameter int ATLAS_HEIGHT = gasc_pkg::ATLAS_HEIGHT_DEF,
  parameter int SLOT_COUNT   = gasc_pkg::SLOT_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic [gasc_pkg::CSLOT_W-1:0] in_cached_slot,
  input  logic [gasc_pkg::GLYPH_W-1:0] in_glyph_width,
  input  logic [gasc_pkg::GLYPH_W-1:0] in_glyph_height,
  output logic                         out_valid,
  output logic [gasc_pkg::OUT_W-1:0]   out_slot,
  output logic [gasc_pkg::OUT_W-1:0]   out_origin_x,
  output logic [gasc_pkg::OUT_W-1:0]   out_origin_y,
  output logic                         out_hit,
  output logic [gasc_pkg::OUT_W-1:0]   out_evict_from,
  output logic [gasc_pkg::OUT_W-1:0]   out_evict_to,
  output logic                         out_flushed
);
  import gasc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gasc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  gasc_dp #(
    .ATLAS_WIDTH  (ATLAS_WIDTH),
    .ATLAS_HEIGHT (ATLAS_HEIGHT),
    .SLOT_COUNT   (SLOT_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_mode),
    .in_cached_slot  (in_cached_slot),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .cmd             (cmd),
    .stat            (stat),
    .out_slot        (out_slot),
    .out_origin_x    (out_origin_x),
    .out_origin_y    (out_origin_y),
    .out_hit         (out_hit),
    .out_evict_from  (out_evict_from),
    .out_evict_to    (out_evict_to),
    .out_flushed     (out_flushed)
  );

  a_flush_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode |=> out_valid && out_flushed && !busy)
    else $error("flush request did not complete in one cycle");

  a_lookup_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_mode |=> busy && !out_valid)
    else $error("lookup request did not enter the sequencer");

  a_no_evict_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_hit || out_flushed) |-> out_evict_from == out_evict_to)
    else $error("hit or flush reported evictions");

  a_hit_not_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_flushed))
    else $error("result marked both hit and flushed");

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for glyph_atlas_shelf_cache_core. A scoreboard class
// tracks the shelf cursor, the slot ring and the per-slot origins, predicts
// every result and compares it with what the core reports. Directed requests
// cover flush, hit, stale and out-of-range slots, clamped sizes, row and top
// wraps and band evictions. Random phases of tiny, small, tall and mixed
// glyphs then fill the ring and drive it through its eviction walks.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int ATLAS_W        = gasc_pkg::ATLAS_WIDTH_DEF;
  localparam int ATLAS_H        = gasc_pkg::ATLAS_HEIGHT_DEF;
  localparam int SLOTS          = gasc_pkg::SLOT_COUNT_DEF;
  localparam int CSLOT_MAX      = (1 << gasc_pkg::CSLOT_W) - 1;
  localparam int EXTENT_MAX     = (1 << gasc_pkg::GLYPH_W) - 1;
  localparam int MAX_GAP        = 12;
  localparam int RANDOM_ITEMS   = 1950;
  localparam int PHASE_ITEMS    = 390;
  localparam int STRETCH_ITEMS  = 60;
  localparam int SETTLE_CYCLES  = 50;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic MODE_PLACE = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;
  localparam logic [gasc_pkg::CSLOT_W-1:0] NOT_CACHED = gasc_pkg::CSLOT_W'(SLOTS);

  localparam int PROFILE_TINY  = 0;
  localparam int PROFILE_SMALL = 1;
  localparam int PROFILE_TALL  = 2;
  localparam int PROFILE_MIXED = 3;
  localparam int PROFILE_ORDER [5] = '{PROFILE_SMALL, PROFILE_TINY, PROFILE_MIXED,
                                       PROFILE_TALL, PROFILE_TINY};

  typedef struct packed {
    logic [gasc_pkg::OUT_W-1:0] slot;
    logic [gasc_pkg::OUT_W-1:0] origin_x;
    logic [gasc_pkg::OUT_W-1:0] origin_y;
    logic                       hit;
    logic [gasc_pkg::OUT_W-1:0] evict_from;
    logic [gasc_pkg::OUT_W-1:0] evict_to;
    logic                       flushed;
  } placement_t;

  class atlas_ledger;
    logic [gasc_pkg::OUT_W-1:0] x_mem [SLOTS];
    logic [gasc_pkg::OUT_W-1:0] y_mem [SLOTS];
    bit                         live [SLOTS];
    int tail, head, cur_x, cur_y, row_h;
    placement_t expected_placements [$];
    int mismatches, checked, hits, misses, flushes, evicted, top_wraps;

    function new();
      x_mem = '{default: '0};
      y_mem = '{default: '0};
      live  = '{default: 1'b0};
      tail = 0;
      head = 0;
      cur_x = 0;
      cur_y = 0;
      row_h = 0;
      mismatches = 0;
      checked = 0;
      hits = 0;
      misses = 0;
      flushes = 0;
      evicted = 0;
      top_wraps = 0;
    endfunction

    function int pending();
      return expected_placements.size();
    endfunction

    function void drop_oldest();
      live[tail] = 1'b0;
      tail = (tail + 1) % SLOTS;
      evicted++;
    endfunction

    function int pick_live_slot();
      int count, s;
      count = (head - tail + SLOTS) % SLOTS;
      if (count == 0) return -1;
      s = (tail + $urandom_range(0, count - 1)) % SLOTS;
      return live[s] ? s : -1;
    endfunction

    function void note_request(logic mode, logic [gasc_pkg::CSLOT_W-1:0] cslot,
                               logic [gasc_pkg::GLYPH_W-1:0] gw,
                               logic [gasc_pkg::GLYPH_W-1:0] gh);
      placement_t p;
      int w, h, band_lo, band_hi;
      p = '0;
      p.evict_from = gasc_pkg::OUT_W'(tail);
      if (mode == MODE_FLUSH) begin
        live = '{default: 1'b0};
        p.flushed = 1'b1;
        flushes++;
      end else if (cslot < SLOTS && live[cslot]) begin
        p.slot     = gasc_pkg::OUT_W'(cslot);
        p.origin_x = x_mem[cslot];
        p.origin_y = y_mem[cslot];
        p.hit      = 1'b1;
        hits++;
      end else begin
        w = (gw > ATLAS_W) ? ATLAS_W : int'(gw);
        h = (gh > ATLAS_H) ? ATLAS_H : int'(gh);
        misses++;
        if (w + cur_x > ATLAS_W) begin
          cur_y += row_h;
          cur_x = 0;
          row_h = 0;
        end
        if (h + cur_y > ATLAS_H) begin
          cur_y = 0;
          cur_x = 0;
          row_h = 0;
          top_wraps++;
          while (tail != head && y_mem[tail] != 0) drop_oldest();
        end
        if (h > row_h) begin
          band_lo = cur_y + row_h;
          band_hi = cur_y + h;
          while (tail != head && int'(y_mem[tail]) >= band_lo &&
                 int'(y_mem[tail]) < band_hi) drop_oldest();
          row_h = h;
        end
        if ((head + 1) % SLOTS == tail) drop_oldest();
        x_mem[head] = gasc_pkg::OUT_W'(cur_x);
        y_mem[head] = gasc_pkg::OUT_W'(cur_y);
        live[head]  = 1'b1;
        p.slot      = gasc_pkg::OUT_W'(head);
        p.origin_x  = gasc_pkg::OUT_W'(cur_x);
        p.origin_y  = gasc_pkg::OUT_W'(cur_y);
        cur_x += w;
        head = (head + 1) % SLOTS;
      end
      p.evict_to = gasc_pkg::OUT_W'(tail);
      expected_placements.push_back(p);
    endfunction

    function void check_result(placement_t got);
      placement_t want;
      checked++;
      if (expected_placements.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result slot %0d origin (%0d,%0d) hit %0b evict %0d..%0d flushed %0b",
                   $time, got.slot, got.origin_x, got.origin_y, got.hit,
                   got.evict_from, got.evict_to, got.flushed);
        return;
      end
      want = expected_placements.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: mismatch on result %0d (expected / actual)", $time, checked);
          $display("  slot %0d / %0d  origin (%0d,%0d) / (%0d,%0d)  hit %0b / %0b",
                   want.slot, got.slot, want.origin_x, want.origin_y,
                   got.origin_x, got.origin_y, want.hit, got.hit);
          $display("  evict %0d..%0d / %0d..%0d  flushed %0b / %0b",
                   want.evict_from, want.evict_to, got.evict_from, got.evict_to,
                   want.flushed, got.flushed);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = MODE_PLACE;
  logic [gasc_pkg::CSLOT_W-1:0] in_cached_slot = '0;
  logic [gasc_pkg::GLYPH_W-1:0] in_glyph_width = '0;
  logic [gasc_pkg::GLYPH_W-1:0] in_glyph_height = '0;
  logic out_valid;
  logic [gasc_pkg::OUT_W-1:0] out_slot, out_origin_x, out_origin_y;
  logic [gasc_pkg::OUT_W-1:0] out_evict_from, out_evict_to;
  logic out_hit, out_flushed;

  atlas_ledger board = new();

  glyph_atlas_shelf_cache_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_cached_slot  (in_cached_slot),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .out_valid       (out_valid),
    .out_slot        (out_slot),
    .out_origin_x    (out_origin_x),
    .out_origin_y    (out_origin_y),
    .out_hit         (out_hit),
    .out_evict_from  (out_evict_from),
    .out_evict_to    (out_evict_to),
    .out_flushed     (out_flushed)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      board.check_result('{slot: out_slot, origin_x: out_origin_x, origin_y: out_origin_y,
                           hit: out_hit, evict_from: out_evict_from,
                           evict_to: out_evict_to, flushed: out_flushed});
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog: no activity for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, board.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [gasc_pkg::GLYPH_W-1:0] draw_extent(int profile);
    case (profile)
      PROFILE_TINY:  return gasc_pkg::GLYPH_W'($urandom_range(0, 2));
      PROFILE_SMALL: return gasc_pkg::GLYPH_W'($urandom_range(1, 24));
      PROFILE_TALL:  return gasc_pkg::GLYPH_W'($urandom_range(8, ATLAS_H));
      default: begin
        if ($urandom_range(0, 9) == 0)
          return gasc_pkg::GLYPH_W'($urandom_range(0, EXTENT_MAX));
        return gasc_pkg::GLYPH_W'($urandom_range(0, 40));
      end
    endcase
  endfunction

  task automatic send_request(logic mode, logic [gasc_pkg::CSLOT_W-1:0] cslot,
                              logic [gasc_pkg::GLYPH_W-1:0] gw,
                              logic [gasc_pkg::GLYPH_W-1:0] gh, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= mode;
    in_cached_slot  <= cslot;
    in_glyph_width  <= gw;
    in_glyph_height <= gh;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_request(mode, cslot, gw, gh);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int roll, live_slot, profile, gap, hit_pct;
    bit quiet;
    logic mode;
    logic [gasc_pkg::CSLOT_W-1:0] cslot;
    logic [gasc_pkg::GLYPH_W-1:0] gw, gh;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_request(MODE_FLUSH, NOT_CACHED, 8'd0, 8'd0, 0);
    send_request(MODE_PLACE, 9'd0, 8'd0, 8'd0, 0);
    send_request(MODE_PLACE, 9'd0, 8'd7, 8'd9, $urandom_range(0, MAX_GAP));
    send_request(MODE_PLACE, NOT_CACHED, 8'd60, 8'd10, 0);
    send_request(MODE_PLACE, NOT_CACHED, 8'd60, 8'd20, 0);
    send_request(MODE_PLACE, 9'd1, 8'd3, 8'd3, $urandom_range(0, MAX_GAP));
    send_request(MODE_PLACE, 9'(CSLOT_MAX), 8'(EXTENT_MAX), 8'd5, 0);
    send_request(MODE_PLACE, NOT_CACHED, 8'd10, 8'(EXTENT_MAX), 0);
    send_request(MODE_PLACE, 9'd256, 8'(ATLAS_W), 8'(ATLAS_H), 0);
    send_request(MODE_PLACE, 9'd5, 8'd0, 8'd0, $urandom_range(0, MAX_GAP));
    send_request(MODE_FLUSH, 9'd5, 8'(EXTENT_MAX), 8'(EXTENT_MAX), 0);
    send_request(MODE_FLUSH, 9'd5, 8'd0, 8'd0, 0);
    send_request(MODE_PLACE, 9'd5, 8'd1, 8'd1, 0);
    send_request(MODE_PLACE, 9'd255, 8'd0, 8'(ATLAS_H), 0);
    send_request(MODE_PLACE, 9'd257, 8'd64, 8'd0, $urandom_range(0, MAX_GAP));
    send_request(MODE_PLACE, 9'd384, 8'(ATLAS_W + 1), 8'(ATLAS_H + 1), 0);
    send_request(MODE_PLACE, NOT_CACHED, 8'd100, 8'd40, 0);
    send_request(MODE_PLACE, NOT_CACHED, 8'd30, 8'd60, 0);
    send_request(MODE_PLACE, NOT_CACHED, 8'd30, 8'd30, 0);
    repeat (4) begin
      live_slot = board.pick_live_slot();
      send_request(MODE_PLACE, (live_slot >= 0) ? 9'(live_slot) : NOT_CACHED,
                   8'd9, 8'd9, $urandom_range(0, MAX_GAP));
    end
    wait_for_results();

    profile = PROFILE_SMALL;
    quiet = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) profile = PROFILE_ORDER[(i / PHASE_ITEMS) % 5];
      if (i % STRETCH_ITEMS == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) wait_for_results();
      hit_pct = (profile == PROFILE_TINY) ? 10 : 43;
      roll = $urandom_range(0, 99);
      mode = MODE_PLACE;
      cslot = NOT_CACHED;
      if (roll < 2) begin
        mode = MODE_FLUSH;
        cslot = 9'($urandom_range(0, CSLOT_MAX));
      end else if (roll < 2 + hit_pct) begin
        live_slot = board.pick_live_slot();
        if (live_slot >= 0) cslot = 9'(live_slot);
      end else if (roll < 9 + hit_pct) begin
        cslot = 9'($urandom_range(0, CSLOT_MAX));
      end else if (roll < 16 + hit_pct) begin
        cslot = 9'($urandom_range(SLOTS, CSLOT_MAX));
      end
      gw = draw_extent(profile);
      gh = draw_extent(profile);
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      send_request(mode, cslot, gw, gh, gap);
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d hits, %0d placements, %0d flushes",
             board.hits + board.misses + board.flushes, board.hits, board.misses,
             board.flushes);
    $display("Ring evicted %0d slots over %0d top wraps; %0d results checked, %0d mismatches",
             board.evicted, board.top_wraps, board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
